// File: src/column_min_max_normalizer_core_assert.svh
// assertion macros shared by the checker
`ifndef COLUMN_MIN_MAX_NORMALIZER_CORE_ASSERT_SVH
`define COLUMN_MIN_MAX_NORMALIZER_CORE_ASSERT_SVH

// same-cycle implication
`define CMMN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMMN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cmmn_pkg.sv
`timescale 1ns / 1ps

package cmmn_pkg;

    localparam int IN_BITS     = 32;
    localparam int COL_BITS    = 4;
    localparam int REQ_BITS    = 2;
    localparam int FRAC_BITS   = 16;
    localparam int SCALED_BITS = FRAC_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(FRAC_BITS);

    localparam logic [REQ_BITS-1:0] REQ_LEARN = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_NORM  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

    localparam logic [SCALED_BITS-1:0] SCALED_ONE  = SCALED_BITS'(1) << FRAC_BITS;
    localparam logic [SCALED_BITS-1:0] SCALED_ZERO = '0;

    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(FRAC_BITS - 1);

    typedef struct packed {
        logic latch;
        logic eval;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [REQ_BITS-1:0] req;
        logic                direct;
        logic                out_free;
    } t_status;

endpackage

// File: src/cmmn_ram.sv
`timescale 1ns / 1ps

module cmmn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/cmmn_ctrl.sv
`timescale 1ns / 1ps

module cmmn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cmmn_pkg::t_status i_status,
    output cmmn_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_DIVIDE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [cmmn_pkg::DIV_CNT_BITS-1:0] r_count;
    logic [cmmn_pkg::DIV_CNT_BITS-1:0] n_count;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_count    = '0;
                if (i_status.req == cmmn_pkg::REQ_NORM) begin
                    n_state = i_status.direct ? S_DONE : S_DIVIDE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_count        = r_count + 1'b1;
                if (r_count == cmmn_pkg::DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: src/cmmn_dp.sv
`timescale 1ns / 1ps

module cmmn_dp #(
    parameter int NUM_COLUMNS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cmmn_pkg::t_cmd                       i_cmd,
    output cmmn_pkg::t_status                    o_status,
    input  logic [cmmn_pkg::REQ_BITS-1:0]        i_req_type,
    input  logic [cmmn_pkg::COL_BITS-1:0]        i_column,
    input  logic signed [cmmn_pkg::IN_BITS-1:0]  i_sample_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [cmmn_pkg::SCALED_BITS-1:0]     o_scaled_value,
    output logic [cmmn_pkg::COL_BITS-1:0]        o_out_column,
    output logic                                 o_clipped,
    output logic                                 o_no_stats
);

    localparam int IDX_BITS = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int RNG_BITS = 9;

    logic [cmmn_pkg::REQ_BITS-1:0]    r_req;
    logic [cmmn_pkg::COL_BITS-1:0]    r_col;
    logic signed [VALUE_BITS-1:0]     r_x;
    logic signed [VALUE_BITS-1:0]     w_x;

    logic [NUM_COLUMNS-1:0]           r_learned;
    logic [IDX_BITS-1:0]              w_idx;
    logic                             w_in_range;
    logic                             w_learned;

    logic                             w_we;
    logic [2*VALUE_BITS-1:0]          w_wdata;
    logic [2*VALUE_BITS-1:0]          w_rdata;
    logic signed [VALUE_BITS-1:0]     w_lo;
    logic signed [VALUE_BITS-1:0]     w_hi;
    logic                             w_lt;
    logic                             w_gt;
    logic                             w_eq;
    logic                             w_le;
    logic                             w_ge;
    logic                             w_direct;
    logic [VALUE_BITS:0]              w_num_full;
    logic [VALUE_BITS:0]              w_den_full;

    logic [VALUE_BITS-1:0]            r_rem;
    logic [VALUE_BITS-1:0]            r_den;
    logic [cmmn_pkg::FRAC_BITS-1:0]   r_quot;
    logic [VALUE_BITS:0]              w_shift;
    logic [VALUE_BITS:0]              w_sub;
    logic                             w_fit;
    logic [VALUE_BITS-1:0]            n_rem;

    logic                             r_direct;
    logic [cmmn_pkg::SCALED_BITS-1:0] r_scaled_direct;
    logic                             r_eval_clipped;
    logic                             r_eval_no_stats;

    logic                             r_out_valid;
    logic [cmmn_pkg::SCALED_BITS-1:0] r_out_scaled;
    logic [cmmn_pkg::COL_BITS-1:0]    r_out_column;
    logic                             r_out_clipped;
    logic                             r_out_no_stats;

    // sample value at the stored width
    generate
        if (VALUE_BITS <= cmmn_pkg::IN_BITS) begin : g_narrow
            assign w_x = i_sample_value[VALUE_BITS-1:0];
        end else begin : g_wide
            assign w_x = {{(VALUE_BITS - cmmn_pkg::IN_BITS){i_sample_value[cmmn_pkg::IN_BITS-1]}},
                          i_sample_value};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req_type;
            r_col <= i_column;
            r_x   <= w_x;
        end
    end

    assign w_in_range = (RNG_BITS'(r_col) < RNG_BITS'(NUM_COLUMNS));
    assign w_idx      = IDX_BITS'(r_col);
    assign w_learned  = w_in_range && r_learned[w_idx];

    // min in low half, max in high half
    cmmn_ram #(
        .WIDTH (2 * VALUE_BITS),
        .DEPTH (NUM_COLUMNS)
    ) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    assign w_lo = w_rdata[VALUE_BITS-1:0];
    assign w_hi = w_rdata[2*VALUE_BITS-1:VALUE_BITS];
    assign w_lt = (r_x < w_lo);
    assign w_gt = (r_x > w_hi);
    assign w_eq = (w_hi == w_lo);
    assign w_le = (r_x <= w_lo);
    assign w_ge = (r_x >= w_hi);

    assign w_we = i_cmd.eval && (r_req == cmmn_pkg::REQ_LEARN) && w_in_range;

    always_comb begin
        if (w_learned) begin
            w_wdata = {(w_gt ? r_x : w_hi), (w_lt ? r_x : w_lo)};
        end else begin
            w_wdata = {r_x, r_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learned <= '0;
        end else if (i_cmd.eval && (r_req == cmmn_pkg::REQ_CLEAR)) begin
            r_learned <= '0;
        end else if (w_we) begin
            r_learned[w_idx] <= 1'b1;
        end
    end

    assign w_direct   = !w_learned || w_eq || w_le || w_ge;
    assign w_num_full = {r_x[VALUE_BITS-1], r_x} - {w_lo[VALUE_BITS-1], w_lo};
    assign w_den_full = {w_hi[VALUE_BITS-1], w_hi} - {w_lo[VALUE_BITS-1], w_lo};

    // restoring division, one quotient bit per step
    assign w_shift = {r_rem, 1'b0};
    assign w_fit   = (w_shift >= {1'b0, r_den});
    assign w_sub   = w_shift - {1'b0, r_den};
    assign n_rem   = w_fit ? w_sub[VALUE_BITS-1:0] : w_shift[VALUE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_rem           <= w_num_full[VALUE_BITS-1:0];
            r_den           <= w_den_full[VALUE_BITS-1:0];
            r_quot          <= '0;
            r_direct        <= w_direct;
            r_eval_clipped  <= w_learned && (w_lt || w_gt);
            r_eval_no_stats <= !w_learned;
            r_scaled_direct <= (w_learned && !w_eq && !w_le && w_ge) ?
                               cmmn_pkg::SCALED_ONE : cmmn_pkg::SCALED_ZERO;
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[cmmn_pkg::FRAC_BITS-2:0], w_fit};
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_scaled   <= r_direct ? r_scaled_direct : {1'b0, r_quot};
            r_out_column   <= r_col;
            r_out_clipped  <= r_eval_clipped;
            r_out_no_stats <= r_eval_no_stats;
        end
    end

    assign o_status.req      = r_req;
    assign o_status.direct   = w_direct;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_scaled_value = r_out_scaled;
    assign o_out_column   = r_out_column;
    assign o_clipped      = r_out_clipped;
    assign o_no_stats     = r_out_no_stats;

endmodule

// File: src/column_min_max_normalizer_core.sv
`timescale 1ns / 1ps

// Per-column min-max scaler. A learn beat (req_type 0) widens the stored minimum and
// maximum of its column, the first one after a clear sets both; a normalize beat
// (req_type 1) returns (x - min) / (max - min) as unsigned Q1.16, truncated, clipped to
// 0 or 1.0 with o_clipped set when x lies outside the learned range, and 0 with
// o_no_stats set when the column has no statistics; a clear beat (req_type 2) forgets
// all columns. One beat is worked at a time. After acceptance a learn, clear or unused beat
// passes through a registered read of the statistics memory and an evaluation step before
// the input is ready again; a normalize beat that needs no division (no statistics, flat
// column, x at or outside the bounds) then loads the output register, and one that divides
// first runs a restoring divider that forms one of the 16 quotient bits per cycle. A
// normalize beat waits for a free output register before loading its result. A result
// waiting at the output does not hold off the next input beat.
module column_min_max_normalizer_core #(
    parameter int NUM_COLUMNS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [cmmn_pkg::REQ_BITS-1:0]        i_req_type,
    input  logic [cmmn_pkg::COL_BITS-1:0]        i_column,
    input  logic signed [cmmn_pkg::IN_BITS-1:0]  i_sample_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [cmmn_pkg::SCALED_BITS-1:0]     o_scaled_value,
    output logic [cmmn_pkg::COL_BITS-1:0]        o_out_column,
    output logic                                 o_clipped,
    output logic                                 o_no_stats
);

    cmmn_pkg::t_cmd    w_cmd;
    cmmn_pkg::t_status w_status;

    cmmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cmmn_dp #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_req_type     (i_req_type),
        .i_column       (i_column),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scaled_value (o_scaled_value),
        .o_out_column   (o_out_column),
        .o_clipped      (o_clipped),
        .o_no_stats     (o_no_stats)
    );

endmodule

// File: src/cmmn_checker.sv
`timescale 1ns / 1ps

`include "column_min_max_normalizer_core_assert.svh"

module cmmn_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic [cmmn_pkg::SCALED_BITS-1:0] o_scaled_value,
    input  logic [cmmn_pkg::COL_BITS-1:0]    o_out_column,
    input  logic                             o_clipped,
    input  logic                             o_no_stats
);

    // stalled output beat holds
    `CMMN_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_scaled_value) && $stable(o_out_column), "output beat changed while stalled")

    // one beat in flight at a time
    `CMMN_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "input ready right after an accepted beat")

    `CMMN_ASSERT_NOW(a_scaled_range, o_out_valid, o_scaled_value <= cmmn_pkg::SCALED_ONE, "scaled value above 1.0")

    // no statistics means zero, unclipped
    `CMMN_ASSERT_NOW(a_no_stats_zero, o_out_valid && o_no_stats, (o_scaled_value == cmmn_pkg::SCALED_ZERO) && !o_clipped, "no_stats beat with nonzero value or clip")

endmodule

bind column_min_max_normalizer_core cmmn_checker u_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_COLS     = 16;
    localparam int ITEM_TARGET  = 1950;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [cmmn_pkg::REQ_BITS-1:0] REQ_UNUSED = 2'd3;
    localparam longint INT_LO = -(longint'(1) << 31);
    localparam longint INT_HI = (longint'(1) << 31) - 1;

    typedef struct {
        logic [cmmn_pkg::SCALED_BITS-1:0] scaled;
        logic [cmmn_pkg::COL_BITS-1:0]    column;
        logic                             clipped;
        logic                             no_stats;
    } t_norm_result;

    class norm_scoreboard;
        longint       col_min [NUM_COLS];
        longint       col_max [NUM_COLS];
        bit           col_learned [NUM_COLS];
        t_norm_result scaled_queue [$];
        int           mismatches;

        function new();
            foreach (col_learned[i]) begin
                col_learned[i] = 1'b0;
                col_min[i] = 0;
                col_max[i] = 0;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return scaled_queue.size();
        endfunction

        // track column statistics and queue the scaled result of a normalize beat
        function void note_request(logic [cmmn_pkg::REQ_BITS-1:0] req,
                                   logic [cmmn_pkg::COL_BITS-1:0] col,
                                   logic signed [cmmn_pkg::IN_BITS-1:0] value);
            t_norm_result r;
            longint x;
            longint lo;
            longint hi;
            longint q;
            x = value;
            case (req)
                cmmn_pkg::REQ_LEARN: begin
                    if (col < NUM_COLS) begin
                        if (!col_learned[col]) begin
                            col_min[col] = x;
                            col_max[col] = x;
                            col_learned[col] = 1'b1;
                        end else begin
                            if (x < col_min[col]) col_min[col] = x;
                            if (x > col_max[col]) col_max[col] = x;
                        end
                    end
                end
                cmmn_pkg::REQ_CLEAR: begin
                    foreach (col_learned[i]) col_learned[i] = 1'b0;
                end
                cmmn_pkg::REQ_NORM: begin
                    r.scaled   = cmmn_pkg::SCALED_ZERO;
                    r.column   = col;
                    r.clipped  = 1'b0;
                    r.no_stats = 1'b0;
                    if (col >= NUM_COLS || !col_learned[col]) begin
                        r.no_stats = 1'b1;
                    end else begin
                        lo = col_min[col];
                        hi = col_max[col];
                        r.clipped = (x < lo) || (x > hi);
                        if (hi == lo || x <= lo) begin
                            r.scaled = cmmn_pkg::SCALED_ZERO;
                        end else if (x >= hi) begin
                            r.scaled = cmmn_pkg::SCALED_ONE;
                        end else begin
                            q = ((x - lo) << cmmn_pkg::FRAC_BITS) / (hi - lo);
                            r.scaled = q[cmmn_pkg::SCALED_BITS-1:0];
                        end
                    end
                    scaled_queue.insert(scaled_queue.size(), r);
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_norm_result got);
            t_norm_result want;
            if (scaled_queue.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual scaled %0d column %0d",
                         $time, got.scaled, got.column);
            end else begin
                want = scaled_queue.pop_front();
                compare_field("scaled_value", want.scaled, got.scaled);
                compare_field("out_column", want.column, got.column);
                compare_field("clipped", want.clipped, got.clipped);
                compare_field("no_stats", want.no_stats, got.no_stats);
            end
        endfunction
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 out_ready = 1'b0;
    logic [cmmn_pkg::REQ_BITS-1:0]        req_type = cmmn_pkg::REQ_LEARN;
    logic [cmmn_pkg::COL_BITS-1:0]        column = '0;
    logic signed [cmmn_pkg::IN_BITS-1:0]  sample_value = '0;
    logic                                 in_ready;
    logic                                 out_valid;
    logic [cmmn_pkg::SCALED_BITS-1:0]     scaled_value;
    logic [cmmn_pkg::COL_BITS-1:0]        out_column;
    logic                                 clipped;
    logic                                 no_stats;

    norm_scoreboard sb = new();

    int     idle_cycles = 0;
    bit     quiet = 1'b0;
    int     valid_odds = 0;
    int     ready_odds = 0;
    int     requests_sent = 0;
    longint stim_lo [NUM_COLS];
    longint stim_hi [NUM_COLS];
    bit     stim_known [NUM_COLS];

    column_min_max_normalizer_core #(
        .NUM_COLUMNS(NUM_COLS),
        .VALUE_BITS (cmmn_pkg::IN_BITS)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_req_type    (req_type),
        .i_column      (column),
        .i_sample_value(sample_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_scaled_value(scaled_value),
        .o_out_column  (out_column),
        .o_clipped     (clipped),
        .o_no_stats    (no_stats)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        t_norm_result got;
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_request(req_type, column, sample_value);
            if (out_valid && out_ready) begin
                got.scaled   = scaled_value;
                got.column   = out_column;
                got.clipped  = clipped;
                got.no_stats = no_stats;
                sb.check_result(got);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // output side back-pressure
    initial begin
        @(posedge clk);
        forever begin
            if (!quiet && ready_odds != 0 && $urandom_range(1, ready_odds) == 1) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    function automatic logic [cmmn_pkg::IN_BITS-1:0] clamp_value(longint v);
        if (v > INT_HI) return cmmn_pkg::IN_BITS'(INT_HI);
        if (v < INT_LO) return cmmn_pkg::IN_BITS'(INT_LO);
        return cmmn_pkg::IN_BITS'(v);
    endfunction

    task automatic send_request(logic [cmmn_pkg::REQ_BITS-1:0] req,
                                logic [cmmn_pkg::COL_BITS-1:0] col,
                                logic [cmmn_pkg::IN_BITS-1:0] value);
        longint x;
        x = longint'(signed'(value));
        if (valid_odds != 0 && $urandom_range(1, valid_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        column       <= col;
        sample_value <= value;
        do @(posedge clk); while (!in_ready);
        if (req != REQ_UNUSED) requests_sent++;
        if (req == cmmn_pkg::REQ_LEARN) begin
            if (!stim_known[col]) begin
                stim_lo[col] = x;
                stim_hi[col] = x;
                stim_known[col] = 1'b1;
            end else begin
                if (x < stim_lo[col]) stim_lo[col] = x;
                if (x > stim_hi[col]) stim_hi[col] = x;
            end
        end else if (req == cmmn_pkg::REQ_CLEAR) begin
            foreach (stim_known[i]) stim_known[i] = 1'b0;
        end
    endtask

    // normalize operand: bounds, just outside them, inside the learned range, or random
    function automatic logic [cmmn_pkg::IN_BITS-1:0] norm_value(
            logic [cmmn_pkg::COL_BITS-1:0] col);
        longint lo;
        longint hi;
        if (!stim_known[col]) return $urandom;
        lo = stim_lo[col];
        hi = stim_hi[col];
        case ($urandom_range(0, 7))
            0: return clamp_value(lo);
            1: return clamp_value(hi);
            2: return clamp_value(lo - $urandom_range(1, 1000));
            3: return clamp_value(hi + $urandom_range(1, 1000));
            4: return $urandom;
            default: return clamp_value(lo + (longint'($urandom) % (hi - lo + 1)));
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            2: return 4;
            default: return 8;
        endcase
    endfunction

    initial begin
        int     span_kind;
        longint base;
        longint span;
        int     ncols;
        logic [cmmn_pkg::COL_BITS-1:0] first_col;
        logic [cmmn_pkg::COL_BITS-1:0] col;
        logic [cmmn_pkg::IN_BITS-1:0]  value;

        foreach (stim_known[i]) begin
            stim_known[i] = 1'b0;
            stim_lo[i] = 0;
            stim_hi[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats
        send_request(cmmn_pkg::REQ_NORM, 4'd0, 32'd17);
        send_request(REQ_UNUSED, 4'd5, 32'hDEAD_BEEF);
        send_request(cmmn_pkg::REQ_LEARN, 4'd15, 32'h7FFF_FFFF);
        send_request(cmmn_pkg::REQ_LEARN, 4'd15, 32'h8000_0000);
        send_request(cmmn_pkg::REQ_NORM, 4'd15, 32'h8000_0000);
        send_request(cmmn_pkg::REQ_NORM, 4'd15, 32'h7FFF_FFFF);
        send_request(cmmn_pkg::REQ_NORM, 4'd15, 32'd0);
        send_request(cmmn_pkg::REQ_NORM, 4'd15, 32'hFFFF_FFFF);
        send_request(cmmn_pkg::REQ_NORM, 4'd15, 32'd1);
        send_request(cmmn_pkg::REQ_LEARN, 4'd3, 32'd42);
        send_request(cmmn_pkg::REQ_NORM, 4'd3, 32'd42);
        send_request(cmmn_pkg::REQ_NORM, 4'd3, 32'd41);
        send_request(cmmn_pkg::REQ_NORM, 4'd3, 32'd43);
        send_request(cmmn_pkg::REQ_LEARN, 4'd7, -32'sd100);
        send_request(cmmn_pkg::REQ_LEARN, 4'd7, 32'd100);
        send_request(cmmn_pkg::REQ_NORM, 4'd7, -32'sd101);
        send_request(cmmn_pkg::REQ_NORM, 4'd7, 32'd101);
        send_request(cmmn_pkg::REQ_NORM, 4'd7, 32'd99);
        send_request(cmmn_pkg::REQ_CLEAR, 4'd0, 32'd0);
        send_request(cmmn_pkg::REQ_NORM, 4'd15, 32'd0);
        send_request(cmmn_pkg::REQ_LEARN, 4'd15, 32'd5);
        send_request(cmmn_pkg::REQ_NORM, 4'd15, 32'd5);

        // random episodes: optional clear, learn pass, normalize pass; some noise
        while (requests_sent < ITEM_TARGET) begin
            quiet = requests_sent > ITEM_TARGET * 9 / 10;
            valid_odds = quiet ? 0 : pick_odds();
            ready_odds = quiet ? 0 : pick_odds();
            if ($urandom_range(0, 9) == 0) begin
                repeat (8) send_request(cmmn_pkg::REQ_BITS'($urandom),
                                        cmmn_pkg::COL_BITS'($urandom), $urandom);
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    send_request(cmmn_pkg::REQ_CLEAR, cmmn_pkg::COL_BITS'($urandom),
                                 $urandom);
                end
                ncols     = $urandom_range(1, 6);
                first_col = cmmn_pkg::COL_BITS'($urandom);
                span_kind = $urandom_range(0, 3);
                base      = longint'(int'($urandom));
                case (span_kind)
                    0: span = 0;
                    1: span = $urandom_range(1, 100);
                    default: span = $urandom_range(1, 1000000);
                endcase
                repeat ($urandom_range(1, 12)) begin
                    col = first_col + cmmn_pkg::COL_BITS'($urandom_range(0, ncols - 1));
                    if (span_kind == 3) value = $urandom;
                    else value = clamp_value(base + $urandom_range(0, span));
                    send_request(cmmn_pkg::REQ_LEARN, col, value);
                end
                repeat ($urandom_range(3, 16)) begin
                    if ($urandom_range(0, 7) == 0) col = cmmn_pkg::COL_BITS'($urandom);
                    else col = first_col + cmmn_pkg::COL_BITS'($urandom_range(0, ncols - 1));
                    send_request(cmmn_pkg::REQ_NORM, col, norm_value(col));
                end
            end
        end
        in_valid <= 1'b0;
        quiet = 1'b1;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
